>>> rtl/core/srup_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srup_pkg;

  localparam int unsigned SRUP_FRAC_BITS = 16;

  // Quotient bits of the kick divider; anything larger saturates the sum anyway
  localparam int unsigned KICK_QW = 34;
  // Quotient bits of the dipole rescale divider (quotient never exceeds the length)
  localparam int unsigned ROT_QW  = 31;
  // Result bits of the norm square root (64-bit radicand)
  localparam int unsigned SQRT_RW = 32;

  localparam logic [1:0] MODE_KICK   = 2'd0;
  localparam logic [1:0] MODE_ROTATE = 2'd1;
  localparam logic [1:0] MODE_SCALE  = 2'd2;

  localparam logic [1:0] CFG_HALF_STEP = 2'd0;
  localparam logic [1:0] CFG_FULL_STEP = 2'd1;
  localparam logic [1:0] CFG_THERMO    = 2'd2;
  localparam logic [1:0] CFG_DISC      = 2'd3;

  // Item fields carried alongside the arithmetic
  typedef struct packed {
    logic [1:0]  mode;
    logic        grp;
    logic        kick_ok;
    logic [30:0] len;
    logic [95:0] om;
    logic [95:0] vec;
  } srup_side_t;

  // Fields carried alongside the rescale divider
  typedef struct packed {
    logic [95:0] pass;
    logic        use_q;
    logic        zero_norm;
    logic [2:0]  sgn;
  } srup_tail_t;

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  function automatic logic [1:0] next_axis(input logic [1:0] a);
    return (a == 2'd2) ? 2'd0 : a + 2'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/srup_delay.sv
`timescale 1ns / 1ps
`default_nettype none

module srup_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

`default_nettype wire

>>> rtl/core/srup_pdiv.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per registered stage.
// Expects num_i < den_i << Q_W; otherwise the quotient is meaningless.
module srup_pdiv #(
  parameter int unsigned NUM_W = 63,
  parameter int unsigned DEN_W = 32,
  parameter int unsigned Q_W   = 31
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [Q_W-1:0]   quo_o
);

  localparam int unsigned CW = DEN_W + Q_W;

  logic [CW-1:0]    rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    localparam int unsigned BIT = Q_W - 1 - j;

    logic [CW-1:0]    rem_in, dsh, rem_d;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in, quo_d;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      dsh      = CW'(den_in) << BIT;
      ge       = rem_in >= dsh;
      rem_d    = ge ? rem_in - dsh : rem_in;
      quo_d    = quo_in;
      quo_d[BIT] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

`default_nettype wire

>>> rtl/core/srup_psqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Floor integer square root, one result bit per registered stage.
module srup_psqrt #(
  parameter int unsigned R_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [2*R_W-1:0] x_i,
  output logic      [R_W-1:0]   root_o
);

  localparam int unsigned TW = 2 * R_W + 1;

  logic [TW-1:0]  rem_q  [R_W];
  logic [R_W-1:0] root_q [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_stage
    localparam int unsigned K = R_W - 1 - j;

    logic [TW-1:0]  rem_in, term, rem_d;
    logic [R_W-1:0] root_in, root_d;
    logic           ge;

    if (j == 0) begin : g_first
      assign rem_in  = TW'(x_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
    always_comb begin
      term      = (TW'(root_in) << (K + 1)) | (TW'(1) << (2 * K));
      ge        = rem_in >= term;
      rem_d     = ge ? rem_in - term : rem_in;
      root_d    = root_in;
      root_d[K] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end
  end

  assign root_o = root_q[R_W-1];

endmodule

`default_nettype wire

>>> rtl/core/sphere_rotation_update_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                    | Content
// ----------+-----------+------------------------------+------------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready| one particle, mode and group in tuser
// m_axis    | out       | m_axis_tvalid / m_axis_tready| updated omega or dipole, flag in tuser
// cfg       | in        | cfg_we_i, no wait            | step factors, thermostat scale, shape
//
// One transaction is taken every cycle while the output is not stalled; its result leaves through the output register.
// The path runs through the front arithmetic (6 stages), the norm square root (32 steps)
// and the dipole rescale divider (31 steps), which sit one behind the other; the kick
// divider (34 steps) runs alongside the square root.
// Reset clears the stage valid bits and sets the configuration registers to their defaults.
// When the output register holds a result that is not taken, every stage holds together;
// nothing is dropped or repeated, and the input is stalled for that cycle.
module sphere_rotation_update_unit
  import srup_pkg::*;
#(
  parameter int unsigned FRAC_BITS = SRUP_FRAC_BITS
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // cfg
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [30:0]  cfg_data_i,
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // omega_x, omega_y, omega_z, vec_x, vec_y, vec_z, radius, mass, dipole_length, pad
  input  wire logic [287:0] s_axis_tdata,
  // mode, in_group
  input  wire logic [2:0]   s_axis_tuser,
  // output stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic      [95:0]  m_axis_tdata,
  // zero_norm
  output logic      [0:0]   m_axis_tuser
);

  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned NUM_W   = 66 + 2 * F;      // kick numerator
  localparam int unsigned KDEN_W  = 94;              // radius^2 * mass * kden
  localparam int unsigned CMP_W   = KDEN_W + KICK_QW;
  localparam int unsigned ST_KQ   = 3 + KICK_QW;     // kick quotient stage
  localparam int unsigned ST_NORM = 6 + SQRT_RW;     // norm stage
  localparam int unsigned OUT_ST  = 40 + ROT_QW;     // output register stage

  // ------------------------------------------------------------------
  // Control: one enable for the whole pipe, valid bits per stage
  // ------------------------------------------------------------------
  logic              en;
  logic [OUT_ST:0]   vld_q;

  assign en            = !vld_q[OUT_ST] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[OUT_ST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[OUT_ST-1:0], s_axis_tvalid};
    end
  end

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [30:0] hsf_q, fstep_q, tscale_q;
  logic        disc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hsf_q    <= '0;
      fstep_q  <= '0;
      tscale_q <= 31'(32'd1 << F);
      disc_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_STEP: hsf_q    <= cfg_data_i;
        CFG_FULL_STEP: fstep_q  <= cfg_data_i;
        CFG_THERMO:    tscale_q <= cfg_data_i;
        CFG_DISC:      disc_q   <= cfg_data_i[0];
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage registers
  // ------------------------------------------------------------------
  // stage 0: captured item
  logic [1:0]         mode_s0_q;
  logic               grp_s0_q;
  logic signed [31:0] om_s0_q [3];
  logic signed [31:0] vec_s0_q [3];
  logic [30:0]        rad_s0_q, mass_s0_q, len_s0_q;

  // kick path
  logic [62:0]        ka_s1_q [3], ka_s1_d [3];
  logic [61:0]        rr_s1_q, rr_s1_d;
  logic [31:0]        mk_s1_q, mk_s1_d;
  logic [65:0]        kn_s2_q [3], kn_s2_d [3];
  logic [62:0]        pplo_s2_q, pplo_s2_d, pphi_s2_q, pphi_s2_d;
  logic [NUM_W-1:0]   num_s3_q [3], num_s3_d [3];
  logic [KDEN_W-1:0]  den_s3_q, den_s3_d;
  logic [2:0]         over_s3, over_s37;
  logic [KICK_QW-1:0] kq_s37 [3];
  logic signed [31:0] resk_s38_q [3], resk_s38_d [3], resk_s39_q [3];

  // rotate path
  logic signed [63:0] p_s1_q [3], p_s1_d [3], n_s1_q [3], n_s1_d [3];
  logic signed [31:0] cr_s2_q [3], cr_s2_d [3];
  logic signed [31:0] vec_s1_q [3], vec_s2_q [3], vec_s3_q [3];
  logic signed [63:0] t_s3_q [3], t_s3_d [3];
  logic signed [31:0] g_s4_q [3], g_s4_d [3];
  logic [63:0]        sq_s5_q [3], sq_s5_d [3];
  logic [63:0]        msq_s6_q, msq_s6_d;
  logic [SQRT_RW-1:0] norm_s38, norm_s39_q;
  logic [95:0]        g_pk_s4, g_pk_s38;
  logic [62:0]        prod_s39_q [3], prod_s39_d [3];
  logic [2:0]         sgn_s39_q, sgn_s39_d;
  logic [ROT_QW-1:0]  rq_s70 [3];

  // scale path
  logic signed [63:0] sp_s39_q [3], sp_s39_d [3];

  srup_side_t side_s0, side_s37, side_s38_q, side_s39_q;
  srup_tail_t tail_s40_q, tail_s40_d, tail_s70;

  logic signed [31:0] out_q [3], out_d [3];
  logic               zn_q;

  // ------------------------------------------------------------------
  // Capture the item
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_s0_q <= s_axis_tuser[1:0];
      grp_s0_q  <= s_axis_tuser[2];
      for (int a = 0; a < 3; a++) begin
        om_s0_q[a]  <= s_axis_tdata[32*a +: 32];
        vec_s0_q[a] <= s_axis_tdata[96 + 32*a +: 32];
      end
      rad_s0_q  <= s_axis_tdata[222:192];
      mass_s0_q <= s_axis_tdata[253:223];
      len_s0_q  <= s_axis_tdata[284:254];
    end
  end

  always_comb begin
    side_s0.mode    = mode_s0_q;
    side_s0.grp     = grp_s0_q;
    side_s0.kick_ok = (rad_s0_q != '0) && (mass_s0_q != '0);
    side_s0.len     = len_s0_q;
    side_s0.om      = {om_s0_q[2], om_s0_q[1], om_s0_q[0]};
    side_s0.vec     = {vec_s0_q[2], vec_s0_q[1], vec_s0_q[0]};
  end

  // ------------------------------------------------------------------
  // Front arithmetic: stages 1 to 6
  // ------------------------------------------------------------------
  always_comb begin
    logic [31:0] mag;
    logic [1:0]  ib, ic;

    // kick: |torque| * hsf, radius^2, mass * kden
    rr_s1_d = 62'(rad_s0_q) * 62'(rad_s0_q);
    mk_s1_d = disc_q ? {1'b0, mass_s0_q} : {mass_s0_q, 1'b0};
    // kick: times knum, denominator partial products
    pplo_s2_d = 63'(rr_s1_q[30:0]) * 63'(mk_s1_q);
    pphi_s2_d = 63'(rr_s1_q[61:31]) * 63'(mk_s1_q);
    // kick: join the denominator
    den_s3_d = (KDEN_W'(pphi_s2_q) << 31) + KDEN_W'(pplo_s2_q);
    // rotate: norm squared
    msq_s6_d = sq_s5_q[0] + sq_s5_q[1] + sq_s5_q[2];

    for (int a = 0; a < 3; a++) begin
      ib  = next_axis(2'(a));
      ic  = next_axis(ib);
      mag = vec_s0_q[a][31] ? 32'(-vec_s0_q[a]) : 32'(vec_s0_q[a]);

      ka_s1_d[a] = 63'(hsf_q) * 63'(mag);
      kn_s2_d[a] = disc_q ? (66'(ka_s1_q[a]) << 1)
                          : (66'(ka_s1_q[a]) << 2) + 66'(ka_s1_q[a]);
      num_s3_d[a] = NUM_W'(kn_s2_q[a]) << (2 * F);
      over_s3[a]  = CMP_W'(num_s3_q[a]) >= (CMP_W'(den_s3_q) << KICK_QW);

      // cross product terms, then omega x mu with floor shifts
      p_s1_d[a]  = om_s0_q[ib] * vec_s0_q[ic];
      n_s1_d[a]  = om_s0_q[ic] * vec_s0_q[ib];
      cr_s2_d[a] = sat32(72'(p_s1_q[a] >>> F) - 72'(n_s1_q[a] >>> F));
      t_s3_d[a]  = $signed({1'b0, fstep_q}) * cr_s2_q[a];
      g_s4_d[a]  = sat32(72'(vec_s3_q[a]) + 72'(t_s3_q[a] >>> F));
      sq_s5_d[a] = g_s4_q[a] * g_s4_q[a];
    end
  end

  assign g_pk_s4 = {g_s4_q[2], g_s4_q[1], g_s4_q[0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_s1_q   <= rr_s1_d;
      mk_s1_q   <= mk_s1_d;
      pplo_s2_q <= pplo_s2_d;
      pphi_s2_q <= pphi_s2_d;
      den_s3_q  <= den_s3_d;
      msq_s6_q  <= msq_s6_d;
      for (int a = 0; a < 3; a++) begin
        ka_s1_q[a]  <= ka_s1_d[a];
        kn_s2_q[a]  <= kn_s2_d[a];
        num_s3_q[a] <= num_s3_d[a];
        p_s1_q[a]   <= p_s1_d[a];
        n_s1_q[a]   <= n_s1_d[a];
        vec_s1_q[a] <= vec_s0_q[a];
        cr_s2_q[a]  <= cr_s2_d[a];
        vec_s2_q[a] <= vec_s1_q[a];
        t_s3_q[a]   <= t_s3_d[a];
        vec_s3_q[a] <= vec_s2_q[a];
        g_s4_q[a]   <= g_s4_d[a];
        sq_s5_q[a]  <= sq_s5_d[a];
      end
    end
  end

  // ------------------------------------------------------------------
  // Long units and the delay lines that keep pace with them
  // ------------------------------------------------------------------
  for (genvar g = 0; g < 3; g++) begin : g_axis
    srup_pdiv #(
      .NUM_W (NUM_W),
      .DEN_W (KDEN_W),
      .Q_W   (KICK_QW)
    ) u_kick_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_s3_q[g]),
      .den_i (den_s3_q),
      .quo_o (kq_s37[g])
    );

    srup_pdiv #(
      .NUM_W (63),
      .DEN_W (SQRT_RW),
      .Q_W   (ROT_QW)
    ) u_rot_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (prod_s39_q[g]),
      .den_i (norm_s39_q),
      .quo_o (rq_s70[g])
    );
  end

  srup_psqrt #(
    .R_W (SQRT_RW)
  ) u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (msq_s6_q),
    .root_o (norm_s38)
  );

  srup_delay #(
    .W ($bits(srup_side_t)),
    .N (ST_KQ)
  ) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side_s0),
    .q_o   (side_s37)
  );

  srup_delay #(
    .W (3),
    .N (KICK_QW)
  ) u_over_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (over_s3),
    .q_o   (over_s37)
  );

  srup_delay #(
    .W (96),
    .N (ST_NORM - 4)
  ) u_g_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (g_pk_s4),
    .q_o   (g_pk_s38)
  );

  srup_delay #(
    .W ($bits(srup_tail_t)),
    .N (ROT_QW - 1)
  ) u_tail_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (tail_s40_q),
    .q_o   (tail_s70)
  );

  // ------------------------------------------------------------------
  // Back arithmetic: stages 38 to 40
  // ------------------------------------------------------------------
  always_comb begin
    logic               neg;
    logic signed [71:0] ksum;
    logic signed [31:0] gv, scl, pv;
    logic [31:0]        absg;
    logic               rot_act;

    rot_act = side_s39_q.grp && (side_s39_q.mode == MODE_ROTATE) && (side_s39_q.len != '0);
    tail_s40_d.use_q     = rot_act && (norm_s39_q != '0);
    tail_s40_d.zero_norm = rot_act && (norm_s39_q == '0);
    tail_s40_d.sgn       = sgn_s39_q;
    tail_s40_d.pass      = '0;

    for (int a = 0; a < 3; a++) begin
      // stage 38: kick sum, saturated; an over-range quotient pins the rail
      neg  = side_s37.vec[32*a + 31];
      ksum = 72'($signed(side_s37.om[32*a +: 32]))
           + (neg ? -72'(kq_s37[a]) : 72'(kq_s37[a]));
      if (over_s37[a]) begin
        resk_s38_d[a] = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        resk_s38_d[a] = sat32(ksum);
      end

      // stage 39: |g| * length, thermostat product
      gv   = $signed(g_pk_s38[32*a +: 32]);
      absg = gv[31] ? 32'(-gv) : 32'(gv);
      prod_s39_d[a] = 63'(absg) * 63'(side_s38_q.len);
      sgn_s39_d[a]  = gv[31];
      sp_s39_d[a]   = $signed(side_s38_q.om[32*a +: 32]) * $signed({1'b0, tscale_q});

      // stage 40: pick the value used when no rescale applies
      scl = sat32(72'(sp_s39_q[a] >>> F));
      if (side_s39_q.mode == MODE_ROTATE) begin
        pv = $signed(side_s39_q.vec[32*a +: 32]);
      end else if (side_s39_q.grp && (side_s39_q.mode == MODE_KICK) && side_s39_q.kick_ok) begin
        pv = resk_s39_q[a];
      end else if (side_s39_q.grp && (side_s39_q.mode == MODE_SCALE)) begin
        pv = scl;
      end else begin
        pv = $signed(side_s39_q.om[32*a +: 32]);
      end
      tail_s40_d.pass[32*a +: 32] = pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_s38_q <= side_s37;
      side_s39_q <= side_s38_q;
      norm_s39_q <= norm_s38;
      sgn_s39_q  <= sgn_s39_d;
      tail_s40_q <= tail_s40_d;
      for (int a = 0; a < 3; a++) begin
        resk_s38_q[a] <= resk_s38_d[a];
        resk_s39_q[a] <= resk_s38_q[a];
        prod_s39_q[a] <= prod_s39_d[a];
        sp_s39_q[a]   <= sp_s39_d[a];
      end
    end
  end

  // ------------------------------------------------------------------
  // Output register: signed rescaled dipole or the carried value
  // ------------------------------------------------------------------
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (tail_s70.use_q) begin
        out_d[a] = tail_s70.sgn[a] ? -$signed(32'(rq_s70[a])) : $signed(32'(rq_s70[a]));
      end else begin
        out_d[a] = $signed(tail_s70.pass[32*a +: 32]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zn_q <= tail_s70.zero_norm;
      for (int a = 0; a < 3; a++) begin
        out_q[a] <= out_d[a];
      end
    end
  end

  assign m_axis_tdata = {out_q[2], out_q[1], out_q[0]};
  assign m_axis_tuser = zn_q;

endmodule

`default_nettype wire

>>> sim/srup_checker.sv
`timescale 1ns / 1ps

// Watches the config port and both streams, predicts each particle update and
// compares it with the result leaving the unit.
module srup_checker
  import srup_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [30:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [0:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o,
  output int           checked_o
);

  typedef struct {
    logic [95:0] vals;
    logic        zflag;
  } update_t;

  logic [30:0] half_step_q, full_step_q, thermo_q;
  logic        disc_q;
  update_t     updates_q[$];

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fff_ffff;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Compute the updated omega or dipole for one particle
  function automatic update_t predict_update(input logic [287:0] d, input logic [2:0] u);
    logic [1:0]          mode;
    logic                grp;
    logic signed [127:0] om[3], vc[3], g[3], cr, q;
    logic [127:0]        rad, mas, len, num, den, mag;
    logic [63:0]         msq, norm;
    logic signed [31:0]  res[3];
    update_t             r;
    mode = u[1:0];
    grp  = u[2];
    for (int a = 0; a < 3; a++) begin
      om[a]  = $signed(d[32*a +: 32]);
      vc[a]  = $signed(d[96 + 32*a +: 32]);
      res[a] = (mode == MODE_ROTATE) ? vc[a][31:0] : om[a][31:0];
    end
    rad     = d[222:192];
    mas     = d[253:223];
    len     = d[284:254];
    r.zflag = 1'b0;
    if (grp && mode == MODE_KICK && rad != 0 && mas != 0) begin
      den = rad * rad * mas * (disc_q ? 128'd1 : 128'd2);
      for (int a = 0; a < 3; a++) begin
        mag = (vc[a] < 0) ? -vc[a] : vc[a];
        num = (128'(half_step_q) * mag * (disc_q ? 128'd2 : 128'd5)) << (2 * SRUP_FRAC_BITS);
        q   = num / den;
        if (q > (128'sd1 << 40)) q = 128'sd1 << 40;
        res[a] = clamp32(om[a] + ((vc[a] < 0) ? -q : q));
      end
    end else if (grp && mode == MODE_ROTATE && len != 0) begin
      msq = '0;
      for (int a = 0; a < 3; a++) begin
        cr = clamp32(((om[(a+1)%3] * vc[(a+2)%3]) >>> SRUP_FRAC_BITS)
                   - ((om[(a+2)%3] * vc[(a+1)%3]) >>> SRUP_FRAC_BITS));
        g[a] = clamp32(vc[a] + (($signed({1'b0, full_step_q}) * cr) >>> SRUP_FRAC_BITS));
        msq  = msq + 64'(g[a] * g[a]);
      end
      norm = floor_sqrt(msq);
      if (norm == 0) begin
        r.zflag = 1'b1;
      end else begin
        for (int a = 0; a < 3; a++) begin
          mag    = (g[a] < 0) ? -g[a] : g[a];
          q      = (mag * len) / norm;
          res[a] = clamp32((g[a] < 0) ? -q : q);
        end
      end
    end else if (grp && mode == MODE_SCALE) begin
      for (int a = 0; a < 3; a++)
        res[a] = clamp32((om[a] * $signed({1'b0, thermo_q})) >>> SRUP_FRAC_BITS);
    end
    r.vals = {res[2], res[1], res[0]};
    return r;
  endfunction

  assign pending_o = updates_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    update_t exp_u;
    if (!rst_ni) begin
      half_step_q  <= '0;
      full_step_q  <= '0;
      thermo_q     <= 31'd1 << SRUP_FRAC_BITS;
      disc_q       <= 1'b0;
      fail_count_o <= 0;
      checked_o    <= 0;
      updates_q.delete();
    end else begin
      // Inputs taken this edge see the registers as they were before it
      if (s_axis_tvalid && s_axis_tready)
        updates_q.push_back(predict_update(s_axis_tdata, s_axis_tuser));
      if (m_axis_tvalid && m_axis_tready) begin
        if (updates_q.size() == 0) begin
          $display("%0t: unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_u = updates_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_u.vals !== m_axis_tdata || exp_u.zflag !== m_axis_tuser[0]) begin
            $display("%0t: mismatch expected %h/%b actual %h/%b", $time,
                     exp_u.vals, exp_u.zflag, m_axis_tdata, m_axis_tuser);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HALF_STEP: half_step_q <= cfg_data_i;
          CFG_FULL_STEP: full_step_q <= cfg_data_i;
          CFG_THERMO:    thermo_q    <= cfg_data_i;
          CFG_DISC:      disc_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the sphere rotation update unit. The checker beside
// the unit predicts every result; this module feeds particles, drives the receiver
// ready, writes the step registers between phases and decides pass or fail.
module tb_top;
  import srup_pkg::*;

  localparam int unsigned LATENCY   = 71;
  localparam int unsigned CYCLE_CAP = 400000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [30:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // omega_x, omega_y, omega_z, vec_x, vec_y, vec_z, radius, mass, dipole_length, pad
  logic [287:0] s_axis_tdata = '0;
  // mode, in_group
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // out_x, out_y, out_z
  logic [95:0]  m_axis_tdata;
  // zero_norm
  logic [0:0]   m_axis_tuser;

  int fail_count, pending, checked;
  int tx_idle_pct, rx_idle_pct;
  int cycle_count;
  int mode_sent[4];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sphere_rotation_update_unit dut (.*);

  srup_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Receiver back-pressure, redrawn every cycle
  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog: hard stop on a hung pipeline
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  // Write one register; called only while the pipeline is empty
  task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_steps(input logic [30:0] hs, fs, th, input logic disc);
    write_reg(CFG_HALF_STEP, hs);
    write_reg(CFG_FULL_STEP, fs);
    write_reg(CFG_THERMO, th);
    write_reg(CFG_DISC, {30'd0, disc});
  endtask

  // Offer one particle; hold it until the unit takes the transaction
  task automatic send_particle(input logic [1:0] mode, input logic grp,
                               input logic [31:0] om[3], input logic [31:0] vc[3],
                               input logic [30:0] rad, mas, len);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {grp, mode};
    s_axis_tdata  <= {3'd0, len, mas, rad, vc[2], vc[1], vc[0], om[2], om[1], om[0]};
    do @(posedge clk_i); while (!s_axis_tready);
    mode_sent[mode]++;
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // Signed word: mostly physically sized values, sometimes anywhere or at a rail
  function automatic logic [31:0] pick_word();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    endcase
  endfunction

  // Positive quantity near 1.0, occasionally anywhere in range
  function automatic logic [30:0] pick_size();
    if ($urandom_range(7) == 0) return 31'($urandom_range(32'h7fff_ffff, 1));
    return 31'($urandom_range(1 << 18, 1 << 13));
  endfunction

  task automatic random_particles(input int count);
    logic [31:0] om[3], vc[3];
    logic [1:0]  mode;
    for (int n = 0; n < count; n++) begin
      for (int a = 0; a < 3; a++) begin
        om[a] = pick_word();
        vc[a] = pick_word();
      end
      mode = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
      // Occasionally zero the dipole so the rotated norm can vanish
      if (mode == MODE_ROTATE && $urandom_range(15) == 0) vc = '{32'd0, 32'd0, 32'd0};
      send_particle(mode, $urandom_range(7) != 0, om, vc, pick_size(), pick_size(),
                    ($urandom_range(9) == 0) ? 31'd0 : pick_size());
    end
  endtask

  initial begin
    logic [31:0] om[3], vc[3], one;
    cycle_count = 0;
    tx_idle_pct = 36;
    rx_idle_pct = 50;
    one = 32'h0001_0000;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset defaults first, then rails, corner cases and every mode
    om = '{one, -one, 32'h7fff_ffff};
    vc = '{32'h8000_0000, one, 32'd0};
    send_particle(MODE_SCALE, 1'b1, om, vc, 31'h10000, 31'h10000, 31'h10000);
    send_particle(MODE_KICK, 1'b1, om, vc, 31'h10000, 31'h10000, 31'h10000);
    drain_pipeline();
    set_steps(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 1'b1);
    for (int m = 0; m < 4; m++) begin
      send_particle(2'(m), 1'b1, om, vc, 31'h10000, 31'h10000, 31'h10000);
      send_particle(2'(m), 1'b0, om, vc, 31'h10000, 31'h10000, 31'h10000);
      send_particle(2'(m), 1'b1, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
                    '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
                    31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff);
    end
    // Zero radius and zero mass leave omega as it was
    send_particle(MODE_KICK, 1'b1, om, vc, 31'd0, 31'h10000, 31'h10000);
    send_particle(MODE_KICK, 1'b1, om, vc, 31'h10000, 31'd0, 31'h10000);
    // No dipole stored, and a dipole that rotates to nothing
    send_particle(MODE_ROTATE, 1'b1, om, vc, 31'h10000, 31'h10000, 31'd0);
    send_particle(MODE_ROTATE, 1'b1, om, '{32'd0, 32'd0, 32'd0}, 31'h10000, 31'h10000,
                  31'h10000);
    send_particle(MODE_KICK, 1'b1, om, vc, 31'd1, 31'd1, 31'd1);
    drain_pipeline();

    // Random phases: receiver-heavy idling, then sender-heavy, then none
    set_steps(31'h0000_0800, 31'h0000_0400, 31'h0000_f000, 1'b0);
    random_particles(100);
    // Hold the sender until the pipeline has emptied, then carry on
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    random_particles(100);
    drain_pipeline();

    tx_idle_pct = 50;
    rx_idle_pct = 36;
    set_steps(31'd0, 31'd0, 31'd0, 1'b1);
    random_particles(60);
    drain_pipeline();
    set_steps(31'h0001_0000, 31'h0002_0000, 31'h0001_8000, 1'b1);
    random_particles(140);
    drain_pipeline();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_steps(31'($urandom()), 31'($urandom_range(1 << 17)), 31'($urandom()), 1'b0);
    random_particles(200);
    drain_pipeline();

    $display("Covered %0d results: kick %0d, rotate %0d, scale %0d, unused mode %0d,",
             checked, mode_sent[0], mode_sent[1], mode_sent[2], mode_sent[3]);
    $display("across several step settings with sender and receiver stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/srup_pkg.sv
rtl/core/srup_delay.sv
rtl/core/srup_pdiv.sv
rtl/core/srup_psqrt.sv
rtl/core/sphere_rotation_update_unit.sv
sim/srup_checker.sv
sim/tb_top.sv
